FILE: hdl/sdtc_pkg.sv
// ----------------------------------------------------------------------------
// sdtc_pkg
// Shared types and constants for the supply and die temperature converter.
// ----------------------------------------------------------------------------
package sdtc_pkg;

  typedef struct packed {
    logic [11:0] reference_reading;
    logic [11:0] sensor_reading;
  } sdtc_in_t;

  typedef struct packed {
    logic        [23:0] supply_millivolts;
    logic signed [31:0] temperature_millidegrees;
    logic               reference_zero;
  } sdtc_out_t;

  // Calibration register indexes.
  typedef enum logic [1:0] {
    REG_REF_MV    = 2'd0,
    REG_MV_AT_25C = 2'd1,
    REG_SLOPE_UV  = 2'd2,
    REG_UNUSED    = 2'd3
  } sdtc_reg_idx_t;

  localparam logic [11:0] REF_MV_RESET    = 12'd1200;
  localparam logic [11:0] MV_AT_25C_RESET = 12'd1430;
  localparam logic [15:0] SLOPE_UV_RESET  = 16'd4300;

  localparam logic [23:0] SUPPLY_MAX     = 24'hFFFFFF;
  localparam logic [9:0]  SCALE_THOUSAND = 10'd1000;
  localparam logic [15:0] OFFSET_MDEG    = 16'd25000;

endpackage

FILE: hdl/sdtc_div.sv
// ----------------------------------------------------------------------------
// sdtc_div
// Pipelined unsigned restoring divider, one quotient bit per register stage,
// with a sideband word that travels alongside each request.
// ----------------------------------------------------------------------------
module sdtc_div #(
  parameter int NW = 24,
  parameter int DW = 12,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [PW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quot,
  output logic [PW-1:0] out_side
);

  logic          vld_r  [1:NW];
  logic [DW-1:0] rem_r  [1:NW];
  logic [NW-1:0] num_r  [1:NW];
  logic [DW-1:0] den_r  [1:NW];
  logic [PW-1:0] side_r [1:NW];

  for (genvar s = 1; s <= NW; s++) begin : g_stage
    logic          prv_vld;
    logic [DW-1:0] prv_rem;
    logic [NW-1:0] prv_num;
    logic [DW-1:0] prv_den;
    logic [PW-1:0] prv_side;
    logic [DW:0]   trial;
    logic          fits;
    logic [DW:0]   diff;
    logic [DW-1:0] rem_nxt;

    if (s == 1) begin : g_first
      assign prv_vld  = in_valid;
      assign prv_rem  = '0;
      assign prv_num  = in_num;
      assign prv_den  = in_den;
      assign prv_side = in_side;
    end else begin : g_next
      assign prv_vld  = vld_r[s-1];
      assign prv_rem  = rem_r[s-1];
      assign prv_num  = num_r[s-1];
      assign prv_den  = den_r[s-1];
      assign prv_side = side_r[s-1];
    end

    always_comb begin
      trial   = {prv_rem, prv_num[NW-1]};
      fits    = (trial >= {1'b0, prv_den});
      diff    = trial - {1'b0, prv_den};
      rem_nxt = fits ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= prv_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        num_r[s]  <= {prv_num[NW-2:0], fits};
        den_r[s]  <= prv_den;
        side_r[s] <= prv_side;
      end
    end
  end

  assign out_valid = vld_r[NW];
  assign out_quot  = num_r[NW];
  assign out_side  = side_r[NW];

endmodule

FILE: hdl/supply_and_die_temperature_converter_unit.sv
// ----------------------------------------------------------------------------
// supply_and_die_temperature_converter_unit
// Converts reference and temperature channel readings into supply millivolts
// and die temperature in milli-degrees Celsius through a deep pipeline.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  in_     | input     | in_valid/in_stall  | reference and sensor readings
//  out_    | output    | out_valid/out_stall| supply, temperature, zero flag
//  cfg_    | input     | cfg_valid/cfg_ready| register index and data
//
// One request enters per cycle while in_stall is low. A request passes through
// SAMPLE_BITS + 65 + NF register stages, the first loaded at its accepting edge.
// NF = 34/(SAMPLE_BITS-1) + 3 is the number of fold stages of the divide by
// full scale, which ends in one correction stage. The bit-per-stage supply
// divider (12+SAMPLE_BITS stages), the temperature divider (45 stages) and
// seven arithmetic and output register stages make up the rest.
// Reset is synchronous and active low; it clears all valid bits and loads the
// calibration registers with their defaults.
// The whole pipeline holds when the output register is full and stalled and a
// finished request is waiting behind it; empty output slots keep it moving.
// ----------------------------------------------------------------------------
module supply_and_die_temperature_converter_unit #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  sdtc_pkg::sdtc_in_t        in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output sdtc_pkg::sdtc_out_t       out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  sdtc_pkg::sdtc_reg_idx_t   cfg_index,
  input  logic [15:0]               cfg_data
);
  import sdtc_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int NW1 = 12 + SB;  // reference_mv * full scale
  localparam int NW2 = SB + 34;  // sensor * supply * 1000
  localparam int NW3 = 45;       // |v25 - vsense| * 1000
  localparam int NF  = 34 / (SB - 1) + 3;  // fold stages of the full scale divide
  localparam logic [SB-1:0] FULL_SCALE = '1;

  // Calibration registers. The user must write them only while the pipeline is
  // idle, which the block itself does not enforce, so every stage reads them directly.
  logic [11:0] ref_mv_r;
  logic [11:0] mv25_r;
  logic [15:0] slope_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_mv_r <= REF_MV_RESET;
      mv25_r   <= MV_AT_25C_RESET;
      slope_r  <= SLOPE_UV_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REF_MV:    ref_mv_r <= cfg_data[11:0];
        REG_MV_AT_25C: mv25_r   <= cfg_data[11:0];
        REG_SLOPE_UV:  slope_r  <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Global advance. The pipeline holds only when the output register is
  // stalled and the last divider stage carries a result that must go there.
  logic adv;
  logic q3_vld;
  logic out_valid_r;

  assign adv      = !(out_valid_r && out_stall && q3_vld);
  assign in_stall = !adv;

  // Stage A: mask readings to the sample width and form the first numerator.
  logic [SB+11:0] ref_ext;
  logic [SB+11:0] sen_ext;
  logic [SB-1:0]  ref_raw;
  logic [SB-1:0]  sen_raw;

  assign ref_ext = {{SB{1'b0}}, in_data.reference_reading};
  assign sen_ext = {{SB{1'b0}}, in_data.sensor_reading};
  assign ref_raw = ref_ext[SB-1:0];
  assign sen_raw = sen_ext[SB-1:0];

  logic           a_vld_r;
  logic [NW1-1:0] a_num_r;
  logic [SB-1:0]  a_den_r;
  logic [SB-1:0]  a_sen_r;
  logic           a_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_num_r  <= NW1'(ref_mv_r) * NW1'(FULL_SCALE);
      // A zero reading divides by one; the quotient is discarded later.
      a_den_r  <= (ref_raw == '0) ? SB'(1) : ref_raw;
      a_sen_r  <= sen_raw;
      a_zero_r <= (ref_raw == '0);
    end
  end

  // Divider 1: supply = reference_mv * full scale / reference reading.
  logic           q1_vld;
  logic [NW1-1:0] q1;
  logic [SB:0]    q1_side;

  sdtc_div #(.NW(NW1), .DW(SB), .PW(SB + 1)) u_div_supply (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (a_vld_r),
    .in_num   (a_num_r),
    .in_den   (a_den_r),
    .in_side  ({a_sen_r, a_zero_r}),
    .out_valid(q1_vld),
    .out_quot (q1),
    .out_side (q1_side)
  );

  // Stage B: saturate the supply, or force it to zero.
  logic [NW1+23:0] q1_ext;
  logic [23:0]     supply_sat;

  always_comb begin
    q1_ext     = (NW1 + 24)'(q1);
    supply_sat = (q1_ext > (NW1 + 24)'(SUPPLY_MAX)) ? SUPPLY_MAX : q1_ext[23:0];
  end

  logic          b_vld_r;
  logic [23:0]   b_supply_r;
  logic [SB-1:0] b_sen_r;
  logic          b_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= q1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_supply_r <= q1_side[0] ? 24'd0 : supply_sat;
      b_sen_r    <= q1_side[SB:1];
      b_zero_r   <= q1_side[0];
    end
  end

  // Stage C: sensor reading times supply.
  logic           c_vld_r;
  logic [SB+23:0] c_prod_r;
  logic [23:0]    c_supply_r;
  logic           c_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_prod_r   <= (SB + 24)'(b_sen_r) * (SB + 24)'(b_supply_r);
      c_supply_r <= b_supply_r;
      c_zero_r   <= b_zero_r;
    end
  end

  // Stage D: scale to microvolts before the constant divide.
  logic           d_vld_r;
  logic [NW2-1:0] d_num_r;
  logic [23:0]    d_supply_r;
  logic           d_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (adv) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_num_r    <= NW2'(c_prod_r) * NW2'(SCALE_THOUSAND);
      d_supply_r <= c_supply_r;
      d_zero_r   <= c_zero_r;
    end
  end

  // Sensor voltage in microvolts = sensor * supply * 1000 / full scale.
  // Full scale is 2^SB - 1, so a value hi*2^SB + lo equals
  // hi*FULL_SCALE + (hi + lo). Each fold stage moves hi into the quotient and
  // keeps hi + lo as the remainder. After NF folds the remainder is at most
  // 2^SB, and one compare and subtract finishes the division.
  logic           fd_vld_r    [1:NF];
  logic [NW2-1:0] fd_quo_r    [1:NF];
  logic [NW2-1:0] fd_rem_r    [1:NF];
  logic [23:0]    fd_supply_r [1:NF];
  logic           fd_zero_r   [1:NF];

  for (genvar f = 1; f <= NF; f++) begin : g_fold
    logic           prv_vld;
    logic [NW2-1:0] prv_quo;
    logic [NW2-1:0] prv_rem;
    logic [23:0]    prv_supply;
    logic           prv_zero;
    logic [NW2-1:0] hi;
    logic [NW2-1:0] lo;

    if (f == 1) begin : g_first
      assign prv_vld    = d_vld_r;
      assign prv_quo    = '0;
      assign prv_rem    = d_num_r;
      assign prv_supply = d_supply_r;
      assign prv_zero   = d_zero_r;
    end else begin : g_next
      assign prv_vld    = fd_vld_r[f-1];
      assign prv_quo    = fd_quo_r[f-1];
      assign prv_rem    = fd_rem_r[f-1];
      assign prv_supply = fd_supply_r[f-1];
      assign prv_zero   = fd_zero_r[f-1];
    end

    assign hi = prv_rem >> SB;
    assign lo = prv_rem & NW2'(FULL_SCALE);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        fd_vld_r[f] <= 1'b0;
      end else if (adv) begin
        fd_vld_r[f] <= prv_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        fd_quo_r[f]    <= prv_quo + hi;
        fd_rem_r[f]    <= hi + lo;
        fd_supply_r[f] <= prv_supply;
        fd_zero_r[f]   <= prv_zero;
      end
    end
  end

  // Correction stage: a remainder of full scale or more adds one.
  logic [NW2-1:0] v_quo_nxt;

  assign v_quo_nxt = (fd_rem_r[NF] >= NW2'(FULL_SCALE)) ? fd_quo_r[NF] + NW2'(1)
                                                         : fd_quo_r[NF];

  logic        v_vld_r;
  logic [33:0] v_uv_r;
  logic [23:0] v_supply_r;
  logic        v_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_vld_r <= 1'b0;
    end else if (adv) begin
      v_vld_r <= fd_vld_r[NF];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v_uv_r     <= v_quo_nxt[33:0];
      v_supply_r <= fd_supply_r[NF];
      v_zero_r   <= fd_zero_r[NF];
    end
  end

  // Stage E: signed difference to the 25 degree voltage, split into sign and
  // magnitude so the next divider can stay unsigned. The sensor voltage never
  // exceeds supply * 1000, which fits in 34 bits.
  logic [35:0] v25_uv;
  logic [35:0] diff_uv;
  logic [35:0] diff_neg;

  always_comb begin
    v25_uv   = 36'(mv25_r) * 36'(SCALE_THOUSAND);
    diff_uv  = v25_uv - {2'b00, v_uv_r};
    diff_neg = -diff_uv;
  end

  logic        e_vld_r;
  logic [34:0] e_mag_r;
  logic        e_neg_r;
  logic [23:0] e_supply_r;
  logic        e_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (adv) begin
      e_vld_r <= v_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_mag_r    <= diff_uv[35] ? diff_neg[34:0] : diff_uv[34:0];
      e_neg_r    <= diff_uv[35];
      e_supply_r <= v_supply_r;
      e_zero_r   <= v_zero_r;
    end
  end

  // Stage F: magnitude times 1000.
  logic           f_vld_r;
  logic [NW3-1:0] f_num_r;
  logic           f_neg_r;
  logic [23:0]    f_supply_r;
  logic           f_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (adv) begin
      f_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_num_r    <= NW3'(e_mag_r) * NW3'(SCALE_THOUSAND);
      f_neg_r    <= e_neg_r;
      f_supply_r <= e_supply_r;
      f_zero_r   <= e_zero_r;
    end
  end

  // Divider 3: divide by the slope; a zero slope register counts as one.
  logic [15:0]    slope_eff;
  logic [NW3-1:0] q3;
  logic [25:0]    q3_side;

  assign slope_eff = (slope_r == 16'd0) ? 16'd1 : slope_r;

  sdtc_div #(.NW(NW3), .DW(16), .PW(26)) u_div_temp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (f_vld_r),
    .in_num   (f_num_r),
    .in_den   (slope_eff),
    .in_side  ({f_supply_r, f_zero_r, f_neg_r}),
    .out_valid(q3_vld),
    .out_quot (q3),
    .out_side (q3_side)
  );

  // Output stage: restore the sign (truncation toward zero), add the
  // 25 degree offset and saturate to 32 bits.
  logic signed [46:0] t_mag;
  logic signed [46:0] t_sum;
  logic signed [31:0] t_sat;

  always_comb begin
    t_mag = $signed({2'b00, q3});
    if (q3_side[0]) begin
      t_mag = -t_mag;
    end
    t_sum = t_mag + $signed(47'(OFFSET_MDEG));
    if (t_sum > $signed(47'(32'h7FFF_FFFF))) begin
      t_sat = 32'sh7FFF_FFFF;
    end else if (t_sum < -$signed(47'(33'h0_8000_0000))) begin
      t_sat = -32'sh7FFF_FFFF - 32'sd1;
    end else begin
      t_sat = t_sum[31:0];
    end
  end

  sdtc_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      if (q3_vld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && q3_vld) begin
      out_data_r.supply_millivolts        <= q3_side[25:2];
      out_data_r.temperature_millidegrees <= t_sat;
      out_data_r.reference_zero           <= q3_side[1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/sdtc_checker.sv
// ----------------------------------------------------------------------------
// sdtc_checker
// Port-level checks for the supply and die temperature converter.
// ----------------------------------------------------------------------------
module sdtc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input sdtc_pkg::sdtc_out_t out_data
);
  import sdtc_pkg::*;

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // An empty output register never blocks new requests.
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // A zero reference reading forces the supply to zero.
  a_zero_supply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reference_zero |-> out_data.supply_millivolts == 24'd0)
    else $error("zero flag with nonzero supply");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind supply_and_die_temperature_converter_unit sdtc_checker u_sdtc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the supply and die temperature converter: random
// and directed reading pairs under several calibrations, checked in order
// against an exact-arithmetic prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import sdtc_pkg::*;

  localparam int LATENCY     = 12 + 64 + 6;
  localparam int WATCH_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  sdtc_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  sdtc_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  sdtc_reg_idx_t cfg_index = REG_REF_MV;
  logic [15:0] cfg_data = '0;

  // Calibration as the bench believes it to be.
  logic [11:0] cal_ref_mv = REF_MV_RESET;
  logic [11:0] cal_mv_25c = MV_AT_25C_RESET;
  logic [15:0] cal_slope  = SLOPE_UV_RESET;

  sdtc_in_t  pending_readings[$];
  sdtc_out_t expected_conversions[$];
  int        errors = 0;
  int        quiet_cycles = 0;
  int        hold_off = 0;   // long receiver hold-off, counted down by the monitor
  bit        stim_done = 1'b0;

  supply_and_die_temperature_converter_unit dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Exact conversion: supply, sensor voltage in uV, then temperature in mdeg.
  function automatic sdtc_out_t convert(sdtc_in_t rd);
    sdtc_out_t      r;
    longint unsigned supply, vsense;
    longint         v25, temp, slope;
    begin
      if (rd.reference_reading == 0) begin
        supply = 0;
        r.reference_zero = 1'b1;
      end else begin
        supply = (longint'(cal_ref_mv) * 4095) / rd.reference_reading;
        if (supply > 24'hFFFFFF) supply = 24'hFFFFFF;
        r.reference_zero = 1'b0;
      end
      vsense = (longint'(rd.sensor_reading) * supply * 1000) / 4095;
      v25 = longint'(cal_mv_25c) * 1000;
      slope = (cal_slope == 0) ? 1 : longint'(cal_slope);
      // SystemVerilog signed division truncates toward zero, as required.
      temp = ((v25 - longint'(vsense)) * 1000) / slope + 25000;
      if (temp > 64'sd2147483647) temp = 64'sd2147483647;
      if (temp < -64'sd2147483648) temp = -64'sd2147483648;
      r.supply_millivolts = supply[23:0];
      r.temperature_millidegrees = temp[31:0];
      return r;
    end
  endfunction

  // Driver: gaps of random length, most short, a few long.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_conversions.push_back(convert(in_data));
        void'(pending_readings.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled request unchanged
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_readings.size() > (in_valid && !in_stall ? 0 : 0) &&
                   pending_readings.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_readings[0];
        send_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                    ($urandom_range(0, 19) == 0 ? $urandom_range(20, 80)
                                                : $urandom_range(1, 4));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result against the oldest prediction and drives stall.
  int recv_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_conversions.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          errors++;
        end else begin
          sdtc_out_t e;
          e = expected_conversions.pop_front();
          if (e.supply_millivolts !== out_data.supply_millivolts)
            $display("%0t: supply exp %0d got %0d", $time,
                     e.supply_millivolts, out_data.supply_millivolts);
          if (e.temperature_millidegrees !== out_data.temperature_millidegrees)
            $display("%0t: temperature exp %0d got %0d", $time,
                     e.temperature_millidegrees, out_data.temperature_millidegrees);
          if (e.reference_zero !== out_data.reference_zero)
            $display("%0t: zero flag exp %0b got %0b", $time,
                     e.reference_zero, out_data.reference_zero);
          if (e !== out_data) errors++;
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        recv_gap <= ($urandom_range(0, 9) < 7) ? 0 :
                    ($urandom_range(0, 19) == 0 ? $urandom_range(20, 80)
                                                : $urandom_range(1, 4));
      end
    end
  end

  // Watchdog: cycles out of reset in which nothing is accepted anywhere.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (rst_n)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic write_cal(sdtc_reg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_REF_MV:    cal_ref_mv = val[11:0];
      REG_MV_AT_25C: cal_mv_25c = val[11:0];
      REG_SLOPE_UV:  cal_slope  = val;
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_readings.size() > 0 || expected_conversions.size() > 0 || in_valid)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic queue_reading(logic [11:0] r, logic [11:0] s);
    sdtc_in_t x;
    x.reference_reading = r;
    x.sensor_reading = s;
    pending_readings.push_back(x);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: queue_reading(12'($urandom_range(0, 3)), 12'($urandom()));
        1: queue_reading(12'($urandom()), 12'($urandom_range(4090, 4095)));
        default: queue_reading(12'($urandom()), 12'($urandom()));
      endcase
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, zero reference, defaults.
    queue_reading(12'd0, 12'd0);
    queue_reading(12'd0, 12'hFFF);
    queue_reading(12'd1, 12'd0);
    queue_reading(12'd1, 12'hFFF);
    queue_reading(12'hFFF, 12'hFFF);
    queue_reading(12'hFFF, 12'd0);
    queue_reading(12'hAAA, 12'h555);
    queue_reading(12'h555, 12'hAAA);
    queue_reading(12'd1489, 12'd1750);
    // Long receiver hold-off while the sender keeps offering.
    hold_off = 400;
    queue_random(300);
    drain();

    // Extreme calibration: zero slope, large reference, zero 25C voltage,
    // with excess bits in the written data.
    write_cal(REG_SLOPE_UV, 16'd0);
    write_cal(REG_REF_MV, 16'hFFFF);
    write_cal(REG_MV_AT_25C, 16'hF000);
    write_cal(REG_UNUSED, 16'h1234);
    queue_reading(12'd1, 12'hFFF);
    queue_reading(12'd0, 12'hFFF);
    queue_reading(12'hFFF, 12'd1);
    queue_random(400);
    drain();

    write_cal(REG_REF_MV, 16'd1);
    write_cal(REG_MV_AT_25C, 16'hFFF);
    write_cal(REG_SLOPE_UV, 16'hFFFF);
    queue_reading(12'd1, 12'd0);
    queue_random(400);
    drain();

    write_cal(REG_SLOPE_UV, 16'd1);
    write_cal(REG_MV_AT_25C, 16'd0);
    write_cal(REG_REF_MV, 16'd4095);
    queue_random(400);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_cal(REG_REF_MV, 16'($urandom()));
      write_cal(REG_MV_AT_25C, 16'($urandom()));
      write_cal(REG_SLOPE_UV, 16'($urandom()));
      queue_random(100);
      drain();
    end

    if (errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
